[design/krt_pkg.sv]
// ============================================================================
// krt_pkg
// Shared types, opcodes and defaults for the keyed record table.
// ============================================================================
package krt_pkg;

    localparam int KRT_CAPACITY = 16;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] key_in;
        logic [3:0]  position;
        logic [63:0] record_data;
    } krt_req_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] key_out;
        logic [63:0] data_out;
        logic [4:0]  entry_count;
    } krt_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;      // capture request, rewind scan
        logic rd_pos;       // read entry at request position
        logic rd_scan;      // read entry at scan index, advance
        logic rd_last;      // read last valid entry
        logic capture_rd;   // take result fields from read data
        logic hit_use_in;   // result payload comes from the request
        logic wr_insert;    // append record under next key
        logic wr_update;    // overwrite payload of the hit entry
        logic del_write;    // move last entry into the hole, shrink
        logic set_fail;     // result is a failure
        logic out_load;     // push result into the output register
    } krt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       not_full;
        logic       pos_ok;
        logic       issue_more;
        logic       cmp_hit;
        logic       out_free;
    } krt_stat_t;

endpackage

[design/krt_ctrl.sv]
// ============================================================================
// krt_ctrl
// Sequencer for the keyed record table: dispatch, scan, move and respond.
// ============================================================================
module krt_ctrl
    import krt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  krt_stat_t stat,
    output krt_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_WAIT,
        S_SCAN,
        S_DEL_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        cmd.wr_insert = stat.not_full;
                        cmd.set_fail  = !stat.not_full;
                        state_next    = S_FINISH;
                    end
                    OP_READ:
                    begin
                        if (stat.pos_ok)
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            cmd.set_fail = 1'b1;
                            state_next   = S_FINISH;
                        end
                    end
                    OP_FIND, OP_DELETE, OP_UPDATE:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        cmd.set_fail = 1'b1;
                        state_next   = S_FINISH;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                cmd.capture_rd = 1'b1;
                state_next     = S_FINISH;
            end
            S_SCAN:
            begin
                priority if (stat.cmp_hit)
                begin
                    cmd.capture_rd = 1'b1;
                    if (stat.op == OP_UPDATE)
                    begin
                        cmd.hit_use_in = 1'b1;
                        cmd.wr_update  = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else if (stat.op == OP_DELETE)
                    begin
                        cmd.rd_last = 1'b1;
                        state_next  = S_DEL_WAIT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (stat.issue_more)
                begin
                    cmd.rd_scan = 1'b1;
                end
                else
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_DEL_WAIT:
            begin
                cmd.del_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign req_stall = stall_reg;

    // Never issue another scan read once a match is on the compare port.
    a_no_read_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_scan |-> !stat.cmp_hit)
        else $error("scan read issued on a hit");

    // The hole fill always uses the last entry read in the previous cycle.
    a_del_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del_write |-> $past(cmd.rd_last))
        else $error("delete write without last-entry read");

    // A result is pushed only into a free output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

endmodule

[design/krt_dpath.sv]
// ============================================================================
// krt_dpath
// Record memories, counters, scan compare and result/output registers.
// ============================================================================
module krt_dpath
    import krt_pkg::*;
#(
    parameter int CAPACITY = KRT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  krt_req_t  req,
    output krt_rsp_t  rsp,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  krt_cmd_t  cmd,
    output krt_stat_t stat
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int ENT_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [15:0] key_mem  [CAPACITY];
    logic [63:0] data_mem [CAPACITY];

    krt_req_t         in_reg;
    logic [CNT_W-1:0] used_reg,     used_next;
    logic [15:0]      key_ctr_reg,  key_ctr_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_valid_reg;
    logic             out_valid_reg, out_valid_next;

    logic [15:0]      rd_key_reg;
    logic [63:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             res_ok_reg;
    logic [15:0]      res_key_reg;
    logic [63:0]      res_data_reg;
    krt_rsp_t         out_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [POS_W-1:0] pos_ext;
    logic [POS_W-1:0] used_pos;
    logic [CNT_W-1:0] last_cnt;
    logic             key_we;
    logic             data_we;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      wr_key;
    logic [63:0]      wr_data;
    logic [ENT_W-1:0] used_ent;

    assign pos_ext  = POS_W'(in_reg.position);
    assign used_pos = POS_W'(used_reg);
    assign last_cnt = used_reg - CNT_W'(1);

    assign stat.op         = in_reg.opcode;
    assign stat.not_full   = (used_reg < CAP_CNT);
    assign stat.pos_ok     = (pos_ext < used_pos);
    assign stat.issue_more = (scan_idx_reg < used_reg);
    assign stat.cmp_hit    = rd_valid_reg && (rd_key_reg == in_reg.key_in);
    assign stat.out_free   = !out_valid_reg || !rsp_stall;

    // Single read port, registered data
    assign rd_en = cmd.rd_pos || cmd.rd_scan || cmd.rd_last;

    always_comb
    begin
        priority if (cmd.rd_pos)
            rd_addr = pos_ext[IDX_W-1:0];
        else if (cmd.rd_last)
            rd_addr = last_cnt[IDX_W-1:0];
        else
            rd_addr = scan_idx_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_data_reg <= data_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Single write port
    assign key_we  = cmd.wr_insert || cmd.del_write;
    assign data_we = cmd.wr_insert || cmd.wr_update || cmd.del_write;

    always_comb
    begin
        priority if (cmd.wr_insert)
        begin
            wr_addr = used_reg[IDX_W-1:0];
            wr_key  = key_ctr_reg;
            wr_data = in_reg.record_data;
        end
        else if (cmd.wr_update)
        begin
            wr_addr = rd_addr_reg;
            wr_key  = rd_key_reg;
            wr_data = in_reg.record_data;
        end
        else
        begin
            wr_addr = hit_idx_reg;
            wr_key  = rd_key_reg;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (data_we)
        begin
            data_mem[wr_addr] <= wr_data;
        end
    end

    // Control counters
    always_comb
    begin
        used_next      = used_reg;
        key_ctr_next   = key_ctr_reg;
        scan_idx_next  = scan_idx_reg;
        out_valid_next = out_valid_reg;
        if (cmd.wr_insert)
        begin
            used_next    = used_reg + CNT_W'(1);
            key_ctr_next = key_ctr_reg + 16'd1;
        end
        else if (cmd.del_write)
        begin
            used_next = last_cnt;
        end
        if (cmd.load_in)
            scan_idx_next = '0;
        else if (cmd.rd_scan)
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            key_ctr_reg   <= 16'd1;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            key_ctr_reg   <= key_ctr_next;
            scan_idx_reg  <= scan_idx_next;
            rd_valid_reg  <= cmd.rd_scan;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result holding registers
    assign used_ent = ENT_W'(used_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= req;
        end
        if (cmd.capture_rd)
        begin
            hit_idx_reg  <= rd_addr_reg;
            res_ok_reg   <= 1'b1;
            res_key_reg  <= rd_key_reg;
            res_data_reg <= cmd.hit_use_in ? in_reg.record_data : rd_data_reg;
        end
        else if (cmd.wr_insert)
        begin
            res_ok_reg   <= 1'b1;
            res_key_reg  <= key_ctr_reg;
            res_data_reg <= in_reg.record_data;
        end
        else if (cmd.set_fail)
        begin
            res_ok_reg   <= 1'b0;
            res_key_reg  <= '0;
            res_data_reg <= '0;
        end
        if (cmd.out_load)
        begin
            out_reg.ok          <= res_ok_reg;
            out_reg.key_out     <= res_key_reg;
            out_reg.data_out    <= res_data_reg;
            out_reg.entry_count <= used_ent[4:0];
        end
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_insert |-> (used_reg < CAP_CNT))
        else $error("insert into a full table");

    a_delete_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del_write |-> (used_reg != '0))
        else $error("delete from an empty table");

endmodule

[design/keyed_record_table.sv]
// ============================================================================
// keyed_record_table
// Unsorted keyed record table with insert, read, find, delete and update.
// ============================================================================
//
//  channel | signals                 | direction | accepted when
//  --------+-------------------------+-----------+-----------------------------
//  request | req_valid, req_stall,req| in        | req_valid && !req_stall
//  result  | rsp_valid, rsp_stall,rsp| out       | rsp_valid && !rsp_stall
//
//  One request is in work at a time; each produces exactly one result.
//  Insert appends directly, read by position reads one entry, and find, update
//  and delete scan from the first entry up to the hit, or over all entries on
//  a miss; delete then reads the last entry and moves it into the hole. The
//  single read port of the record memories sets the scan to one entry a cycle.
//  Reset clears the count and sets the key counter to one; memories are not
//  cleared. A held result sits in the output register while the next request
//  is taken; the sequencer stalls only at the end of that next request.
//
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = KRT_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  krt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output krt_rsp_t rsp
);

    // Command and status between sequencer and datapath
    krt_cmd_t  cmd;
    krt_stat_t stat;

    // Sequencer: dispatch on opcode, drive the scan, move last entry on delete
    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: memories, counters, compare and the output register
    krt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
